[design/wsht_pkg.sv]
`default_nettype none

package wsht_pkg;

  // Default sizes
  localparam int MAX_WINDOWS_DEF = 16;
  localparam int COORD_BITS_DEF  = 12;

  // Width of the window number on the result channel
  localparam int ID_BITS = 5;

  // Item kind codes
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_CLICK = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_HIT    = 2'd0,
    STAT_MISS   = 2'd1,
    STAT_LOADED = 2'd2,
    STAT_FULL   = 2'd3
  } status_e;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_e;

  // Per-cell update command
  typedef struct packed {
    logic load;   // write the new rectangle into this cell
    logic shift;  // take the contents of the cell above
    logic top;    // take the saved (hit) window
  } cell_ctrl_t;

endpackage

`default_nettype wire

[design/wsht_cell.sv]
`default_nettype none

module wsht_cell #(
  parameter int COORD_BITS = wsht_pkg::COORD_BITS_DEF,
  parameter int NUM_BITS   = 5
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire wsht_pkg::cell_ctrl_t   ctrl_i,
  input  wire logic [COORD_BITS-1:0]  click_x_i,
  input  wire logic [COORD_BITS-1:0]  click_y_i,
  input  wire logic [COORD_BITS-1:0]  load_lx_i,
  input  wire logic [COORD_BITS-1:0]  load_ty_i,
  input  wire logic [COORD_BITS-1:0]  load_rx_i,
  input  wire logic [COORD_BITS-1:0]  load_by_i,
  input  wire logic [NUM_BITS-1:0]    load_num_i,
  input  wire logic [COORD_BITS-1:0]  above_lx_i,
  input  wire logic [COORD_BITS-1:0]  above_ty_i,
  input  wire logic [COORD_BITS-1:0]  above_rx_i,
  input  wire logic [COORD_BITS-1:0]  above_by_i,
  input  wire logic [NUM_BITS-1:0]    above_num_i,
  input  wire logic [COORD_BITS-1:0]  saved_lx_i,
  input  wire logic [COORD_BITS-1:0]  saved_ty_i,
  input  wire logic [COORD_BITS-1:0]  saved_rx_i,
  input  wire logic [COORD_BITS-1:0]  saved_by_i,
  input  wire logic [NUM_BITS-1:0]    saved_num_i,
  output logic      [COORD_BITS-1:0]  lx_o,
  output logic      [COORD_BITS-1:0]  ty_o,
  output logic      [COORD_BITS-1:0]  rx_o,
  output logic      [COORD_BITS-1:0]  by_o,
  output logic      [NUM_BITS-1:0]    num_o,
  output logic                        hit_o
);

  logic [COORD_BITS-1:0] lx_q, ty_q, rx_q, by_q;
  logic [NUM_BITS-1:0]   num_q;
  logic                  hit_d, hit_q;

  // Inclusive point-in-rectangle test
  assign hit_d = (click_x_i >= lx_q) && (click_x_i <= rx_q) &&
                 (click_y_i >= ty_q) && (click_y_i <= by_q);

  // Register the compare result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  // Load, shift down from the neighbor, or take the window moved to the top
  always_ff @(posedge clk_i) begin
    priority if (ctrl_i.load) begin
      lx_q  <= load_lx_i;
      ty_q  <= load_ty_i;
      rx_q  <= load_rx_i;
      by_q  <= load_by_i;
      num_q <= load_num_i;
    end else if (ctrl_i.shift) begin
      lx_q  <= above_lx_i;
      ty_q  <= above_ty_i;
      rx_q  <= above_rx_i;
      by_q  <= above_by_i;
      num_q <= above_num_i;
    end else if (ctrl_i.top) begin
      lx_q  <= saved_lx_i;
      ty_q  <= saved_ty_i;
      rx_q  <= saved_rx_i;
      by_q  <= saved_by_i;
      num_q <= saved_num_i;
    end
  end

  assign lx_o  = lx_q;
  assign ty_o  = ty_q;
  assign rx_o  = rx_q;
  assign by_o  = by_q;
  assign num_o = num_q;
  assign hit_o = hit_q;

endmodule

`default_nettype wire

[design/wsht_pick.sv]
`default_nettype none

module wsht_pick #(
  parameter int MAX_WINDOWS = wsht_pkg::MAX_WINDOWS_DEF
) (
  input  wire logic [MAX_WINDOWS-1:0] hit_i,
  output logic                        found_o,
  output logic      [MAX_WINDOWS-1:0] sel_o,
  output logic      [MAX_WINDOWS-1:0] ge_o
);

  // A cell is at or above the topmost hit when no hit lies strictly above it
  always_comb begin
    for (int i = 0; i < MAX_WINDOWS; i++) begin
      ge_o[i]  = ((hit_i >> (i + 1)) == '0);
      sel_o[i] = hit_i[i] & ge_o[i];
    end
  end

  assign found_o = |hit_i;

endmodule

`default_nettype wire

[design/window_stack_hit_test.sv]
// A result reaches the output register once the accepted transaction has passed
// the compare (CMP) and update (UPD) states; the registered compare in each cell
// and the following shift/update step mean a new transaction is taken only in idle.
// A finished result waits in an output register; the stack stalls only if it
// is still untaken when the next update is due.
// Reset (rst_ni low, asynchronous) empties the stack and drops any result.
`default_nettype none

module window_stack_hit_test #(
  parameter int MAX_WINDOWS = wsht_pkg::MAX_WINDOWS_DEF,
  parameter int COORD_BITS  = wsht_pkg::COORD_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  kind_i,
  input  wire logic [COORD_BITS-1:0] left_x_i,
  input  wire logic [COORD_BITS-1:0] top_y_i,
  input  wire logic [COORD_BITS-1:0] right_x_i,
  input  wire logic [COORD_BITS-1:0] bottom_y_i,
  input  wire logic [COORD_BITS-1:0] click_x_i,
  input  wire logic [COORD_BITS-1:0] click_y_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [1:0]                 status_o,
  output logic [wsht_pkg::ID_BITS-1:0] window_id_o
);

  localparam int CntW = $clog2(MAX_WINDOWS + 1);

  wsht_pkg::state_e  state_q, state_d;
  wsht_pkg::status_e status_q, status_d;
  logic [wsht_pkg::ID_BITS-1:0] id_q, id_d;
  logic              out_valid_q;
  logic [CntW-1:0]   count_q;

  // Held transaction
  logic                  kind_q;
  logic [COORD_BITS-1:0] lx_q, ty_q, rx_q, by_q, cx_q, cy_q;

  // Cell chain signals
  logic [COORD_BITS-1:0] c_lx  [MAX_WINDOWS];
  logic [COORD_BITS-1:0] c_ty  [MAX_WINDOWS];
  logic [COORD_BITS-1:0] c_rx  [MAX_WINDOWS];
  logic [COORD_BITS-1:0] c_by  [MAX_WINDOWS];
  logic [CntW-1:0]       c_num [MAX_WINDOWS];
  logic [MAX_WINDOWS-1:0] c_hit, hit_vec, sel, ge;
  wsht_pkg::cell_ctrl_t  ctrl [MAX_WINDOWS];

  logic [COORD_BITS-1:0] sv_lx, sv_ty, sv_rx, sv_by;
  logic [CntW-1:0]       sv_num;
  logic                  found, full, accept, advance, is_load;
  logic [CntW-1:0]       load_num;

  assign accept   = in_valid_i && in_ready_o;
  assign advance  = (state_q == wsht_pkg::S_UPD) && (!out_valid_q || out_ready_i);
  assign is_load  = (kind_q == wsht_pkg::KIND_LOAD);
  assign full     = (count_q == CntW'(MAX_WINDOWS));
  assign load_num = count_q + CntW'(1);

  // Sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wsht_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and input handshake
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      wsht_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) state_d = wsht_pkg::S_CMP;
      end
      wsht_pkg::S_CMP: state_d = wsht_pkg::S_UPD;
      wsht_pkg::S_UPD: begin
        if (advance) state_d = wsht_pkg::S_IDLE;
      end
      default: state_d = wsht_pkg::S_IDLE;
    endcase
  end

  // Hold the accepted transaction
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      lx_q   <= left_x_i;
      ty_q   <= top_y_i;
      rx_q   <= right_x_i;
      by_q   <= bottom_y_i;
      cx_q   <= click_x_i;
      cy_q   <= click_y_i;
    end
  end

  // Row of cells; cell 0 is the bottom of the stack
  for (genvar g = 0; g < MAX_WINDOWS; g++) begin : g_cell
    localparam int Up = (g == MAX_WINDOWS - 1) ? g : g + 1;

    // Only cells below the fill count take part
    assign hit_vec[g] = c_hit[g] && (CntW'(g) < count_q);

    always_comb begin
      ctrl[g].load  = advance && is_load && !full && (CntW'(g) == count_q);
      ctrl[g].shift = advance && !is_load && found && ge[g] &&
                      (CntW'(g + 1) < count_q);
      ctrl[g].top   = advance && !is_load && found && (CntW'(g + 1) == count_q);
    end

    wsht_cell #(
      .COORD_BITS (COORD_BITS),
      .NUM_BITS   (CntW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl[g]),
      .click_x_i   (cx_q),
      .click_y_i   (cy_q),
      .load_lx_i   (lx_q),
      .load_ty_i   (ty_q),
      .load_rx_i   (rx_q),
      .load_by_i   (by_q),
      .load_num_i  (load_num),
      .above_lx_i  (c_lx[Up]),
      .above_ty_i  (c_ty[Up]),
      .above_rx_i  (c_rx[Up]),
      .above_by_i  (c_by[Up]),
      .above_num_i (c_num[Up]),
      .saved_lx_i  (sv_lx),
      .saved_ty_i  (sv_ty),
      .saved_rx_i  (sv_rx),
      .saved_by_i  (sv_by),
      .saved_num_i (sv_num),
      .lx_o        (c_lx[g]),
      .ty_o        (c_ty[g]),
      .rx_o        (c_rx[g]),
      .by_o        (c_by[g]),
      .num_o       (c_num[g]),
      .hit_o       (c_hit[g])
    );
  end

  // Find the topmost hit
  wsht_pick #(
    .MAX_WINDOWS (MAX_WINDOWS)
  ) u_pick (
    .hit_i   (hit_vec),
    .found_o (found),
    .sel_o   (sel),
    .ge_o    (ge)
  );

  // Select the hit window with a one-hot AND-OR
  always_comb begin
    sv_lx  = '0;
    sv_ty  = '0;
    sv_rx  = '0;
    sv_by  = '0;
    sv_num = '0;
    for (int i = 0; i < MAX_WINDOWS; i++) begin
      sv_lx  |= c_lx[i]  & {COORD_BITS{sel[i]}};
      sv_ty  |= c_ty[i]  & {COORD_BITS{sel[i]}};
      sv_rx  |= c_rx[i]  & {COORD_BITS{sel[i]}};
      sv_by  |= c_by[i]  & {COORD_BITS{sel[i]}};
      sv_num |= c_num[i] & {CntW{sel[i]}};
    end
  end

  // Advance the fill count on a successful load
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (advance && is_load && !full) begin
      count_q <= load_num;
    end
  end

  // Form the result
  always_comb begin
    if (is_load) begin
      status_d = full ? wsht_pkg::STAT_FULL : wsht_pkg::STAT_LOADED;
      id_d     = full ? '0 : wsht_pkg::ID_BITS'(load_num);
    end else begin
      status_d = found ? wsht_pkg::STAT_HIT : wsht_pkg::STAT_MISS;
      id_d     = found ? wsht_pkg::ID_BITS'(sv_num) : '0;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      status_q <= status_d;
      id_q     <= id_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign window_id_o = id_q;

endmodule

`default_nettype wire

[bench/tb_window_stack_hit_test.sv]
module tb_window_stack_hit_test;

  localparam int MAX_W       = wsht_pkg::MAX_WINDOWS_DEF;
  localparam int CB          = wsht_pkg::COORD_BITS_DEF;
  localparam int ID_W        = wsht_pkg::ID_BITS;
  localparam int CMAX        = (1 << CB) - 1;
  localparam int RANDOM_OPS  = 1325;
  localparam int TAIL_CYCLES = 12;
  localparam int CYCLE_LIMIT = 200000;

  typedef logic [CB-1:0] coord_t;

  typedef struct packed {
    coord_t lx;
    coord_t ty;
    coord_t rx;
    coord_t by;
  } rect_t;

  typedef struct packed {
    wsht_pkg::status_e status;
    logic [ID_W-1:0]   id;
  } outcome_t;

  typedef struct {
    logic     kind;
    rect_t    rect;
    coord_t   cx;
    coord_t   cy;
    bit       fixed;      // outcome typed in below instead of predicted
    outcome_t fixed_res;
  } stack_op_t;

  logic            clk_i;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  logic            in_ready;
  logic            kind      = wsht_pkg::KIND_LOAD;
  coord_t          left_x    = '0;
  coord_t          top_y     = '0;
  coord_t          right_x   = '0;
  coord_t          bottom_y  = '0;
  coord_t          click_x   = '0;
  coord_t          click_y   = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic [1:0]      status;
  logic [ID_W-1:0] window_id;

  window_stack_hit_test dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .kind_i      (kind),
    .left_x_i    (left_x),
    .top_y_i     (top_y),
    .right_x_i   (right_x),
    .bottom_y_i  (bottom_y),
    .click_x_i   (click_x),
    .click_y_i   (click_y),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .status_o    (status),
    .window_id_o (window_id)
  );

  // Shadow copy of the window stack; index 0 is the bottom
  rect_t    stack_rect [MAX_W];
  int       stack_num  [MAX_W];
  int       stack_depth = 0;

  outcome_t  pending_results[$];
  stack_op_t directed_ops[$];

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int errors         = 0;
  int cycle_count    = 0;
  int n_loaded       = 0;
  int n_refused      = 0;
  int n_hits         = 0;
  int n_misses       = 0;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Apply one transaction to the shadow stack and return its outcome
  function automatic outcome_t apply_to_stack(stack_op_t op);
    outcome_t res;
    int       hit;
    int       i;
    rect_t    saved_rect;
    int       saved_num;
    res.status = wsht_pkg::STAT_MISS;
    res.id     = '0;
    hit        = -1;
    if (op.kind == wsht_pkg::KIND_LOAD) begin
      if (stack_depth >= MAX_W) begin
        res.status = wsht_pkg::STAT_FULL;
      end else begin
        stack_rect[stack_depth] = op.rect;
        stack_num[stack_depth]  = stack_depth + 1;
        res.id                  = ID_W'(stack_depth + 1);
        res.status              = wsht_pkg::STAT_LOADED;
        stack_depth++;
      end
    end else begin
      // Search from the top down, with inclusive bounds on both axes
      for (i = stack_depth - 1; i >= 0 && hit < 0; i--) begin
        if (op.cx >= stack_rect[i].lx && op.cx <= stack_rect[i].rx &&
            op.cy >= stack_rect[i].ty && op.cy <= stack_rect[i].by) begin
          hit = i;
        end
      end
      if (hit >= 0) begin
        // Move the hit window to the top, shift the ones above it down
        saved_rect = stack_rect[hit];
        saved_num  = stack_num[hit];
        for (i = hit; i < stack_depth - 1; i++) begin
          stack_rect[i] = stack_rect[i + 1];
          stack_num[i]  = stack_num[i + 1];
        end
        stack_rect[stack_depth - 1] = saved_rect;
        stack_num[stack_depth - 1]  = saved_num;
        res.status = wsht_pkg::STAT_HIT;
        res.id     = ID_W'(saved_num);
      end
    end
    return res;
  endfunction

  // Pick a coordinate on, inside, or just outside the span [lo, hi]
  function automatic coord_t pick_near(coord_t lo, coord_t hi);
    case ($urandom_range(0, 9))
      0:       return lo;
      1:       return hi;
      2:       return lo - 1'b1;
      3:       return hi + 1'b1;
      default: return coord_t'(lo + $urandom_range(0, hi - lo));
    endcase
  endfunction

  function automatic rect_t random_rect();
    rect_t r;
    r.lx = coord_t'($urandom_range(0, 3000));
    r.ty = coord_t'($urandom_range(0, 3000));
    r.rx = coord_t'(r.lx + $urandom_range(0, 1095));
    r.by = coord_t'(r.ty + $urandom_range(0, 1095));
    return r;
  endfunction

  function automatic void add_row(logic op_kind, rect_t r, int cx, int cy, bit fixed,
                                  wsht_pkg::status_e st, int id);
    stack_op_t op;
    op.kind             = op_kind;
    op.rect             = r;
    op.cx               = coord_t'(cx);
    op.cy               = coord_t'(cy);
    op.fixed            = fixed;
    op.fixed_res.status = st;
    op.fixed_res.id     = ID_W'(id);
    directed_ops.push_back(op);
  endfunction

  // Drive one transaction; called and left at a falling edge
  task automatic drive_op(input stack_op_t op);
    outcome_t res;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    kind     <= op.kind;
    left_x   <= op.rect.lx;
    top_y    <= op.rect.ty;
    right_x  <= op.rect.rx;
    bottom_y <= op.rect.by;
    click_x  <= op.cx;
    click_y  <= op.cy;
    do @(posedge clk_i); while (!in_ready);
    res = apply_to_stack(op);
    pending_results.push_back(op.fixed ? op.fixed_res : res);
    @(negedge clk_i);
  endtask

  // Receiver: stall at random
  initial begin
    forever begin
      @(negedge clk_i);
      out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // Check each result transaction against the oldest expectation
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: status %0d window %0d",
                 $time, status, window_id);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.status, status);
          errors++;
        end
        if (window_id !== want.id) begin
          $display("%0t: window_id mismatch: expected %0d, actual %0d",
                   $time, want.id, window_id);
          errors++;
        end
        case (wsht_pkg::status_e'(status))
          wsht_pkg::STAT_HIT:    n_hits++;
          wsht_pkg::STAT_MISS:   n_misses++;
          wsht_pkg::STAT_LOADED: n_loaded++;
          default:               n_refused++;
        endcase
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("window_stack_hit_test regression: fail");
    $finish;
  end

  // Stimulus
  initial begin
    stack_op_t op;
    rect_t     r;
    int        phase;
    int        n;
    int        idx;
    int        phase_ops;

    // Click on an empty stack
    add_row(wsht_pkg::KIND_CLICK, '0, 0, 0, 1, wsht_pkg::STAT_MISS, 0);
    // Point-sized windows in opposite corners, then two inverted ones
    add_row(wsht_pkg::KIND_LOAD, '{0, 0, 0, 0}, 0, 0, 1, wsht_pkg::STAT_LOADED, 1);
    add_row(wsht_pkg::KIND_LOAD, '{CMAX, CMAX, CMAX, CMAX}, 0, 0, 1,
            wsht_pkg::STAT_LOADED, 2);
    add_row(wsht_pkg::KIND_LOAD, '{200, 100, 199, 300}, CMAX, CMAX, 1,
            wsht_pkg::STAT_LOADED, 3);
    add_row(wsht_pkg::KIND_LOAD, '{10, 500, 20, 499}, 0, 0, 1, wsht_pkg::STAT_LOADED, 4);
    // Hit buried windows; rectangle fields on a click are ignored
    add_row(wsht_pkg::KIND_CLICK, '0, 0, 0, 1, wsht_pkg::STAT_HIT, 1);
    add_row(wsht_pkg::KIND_CLICK, '{CMAX, CMAX, CMAX, CMAX}, CMAX, CMAX, 1,
            wsht_pkg::STAT_HIT, 2);
    // Inverted windows never hit; a point next to a corner misses
    add_row(wsht_pkg::KIND_CLICK, '0, 200, 200, 1, wsht_pkg::STAT_MISS, 0);
    add_row(wsht_pkg::KIND_CLICK, '0, 0, 1, 1, wsht_pkg::STAT_MISS, 0);
    // Full screen window plus two overlapping ones
    add_row(wsht_pkg::KIND_LOAD, '{0, 0, CMAX, CMAX}, 0, 0, 1, wsht_pkg::STAT_LOADED, 5);
    add_row(wsht_pkg::KIND_LOAD, '{100, 100, 2000, 2000}, 0, 0, 0, wsht_pkg::STAT_HIT, 0);
    add_row(wsht_pkg::KIND_LOAD, '{1000, 1000, 3000, 3000}, 0, 0, 0,
            wsht_pkg::STAT_HIT, 0);
    // Top window hit, then reorder
    add_row(wsht_pkg::KIND_CLICK, '0, 1500, 1500, 0, wsht_pkg::STAT_HIT, 0);
    add_row(wsht_pkg::KIND_CLICK, '0, 500, 500, 0, wsht_pkg::STAT_HIT, 0);
    add_row(wsht_pkg::KIND_CLICK, '0, 3500, 3500, 0, wsht_pkg::STAT_HIT, 0);
    // Fill the stack, then one load too many
    for (n = 0; n < MAX_W - 7; n++) begin
      add_row(wsht_pkg::KIND_LOAD, random_rect(), $urandom, $urandom, 0,
              wsht_pkg::STAT_HIT, 0);
    end
    add_row(wsht_pkg::KIND_LOAD, '{5, 5, 6, 6}, 0, 0, 1, wsht_pkg::STAT_FULL, 0);

    // Hold reset, then release it on a falling clock edge
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct   = 28;
          sink_stall_pct = 65;
        end
        1: begin
          src_idle_pct   = 65;
          sink_stall_pct = 28;
        end
        default: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
      endcase
      if (phase == 0) begin
        foreach (directed_ops[k]) drive_op(directed_ops[k]);
      end
      phase_ops = (phase == 2) ? RANDOM_OPS - 2 * (RANDOM_OPS / 3) : RANDOM_OPS / 3;
      for (n = 0; n < phase_ops; n++) begin
        op.fixed    = 1'b0;
        op.rect.lx  = coord_t'($urandom);
        op.rect.ty  = coord_t'($urandom);
        op.rect.rx  = coord_t'($urandom);
        op.rect.by  = coord_t'($urandom);
        op.cx       = coord_t'($urandom);
        op.cy       = coord_t'($urandom);
        if ($urandom_range(0, 9) == 0) begin
          op.kind = wsht_pkg::KIND_LOAD;
        end else begin
          op.kind = wsht_pkg::KIND_CLICK;
          // Aim most clicks at or around a window in the stack
          if (stack_depth > 0 && $urandom_range(0, 4) != 0) begin
            idx = $urandom_range(0, stack_depth - 1);
            r   = stack_rect[idx];
            if (r.lx <= r.rx) op.cx = pick_near(r.lx, r.rx);
            if (r.ty <= r.by) op.cy = pick_near(r.ty, r.by);
          end
        end
        drive_op(op);
      end
    end
    in_valid <= 1'b0;

    // Drain
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Checked %0d loads, %0d refused loads, %0d hits, %0d misses",
             n_loaded, n_refused, n_hits, n_misses);
    $display("Stack depth %0d of %0d, three idle/stall mixes, %0d errors",
             stack_depth, MAX_W, errors);
    if (errors == 0) begin
      $display("window_stack_hit_test regression: pass");
    end else begin
      $display("window_stack_hit_test regression: fail");
    end
    $finish;
  end

endmodule

[window_stack_hit_test.f]
design/wsht_pkg.sv
design/wsht_cell.sv
design/wsht_pick.sv
design/window_stack_hit_test.sv
bench/tb_window_stack_hit_test.sv
